FILE: sv/rspf_pkg.sv
// Package for the RSP packet framer and escaper.
// Holds the framing characters, the job descriptor passed from the front to
// the back, and small helper functions. Depends on nothing.
package rspf_pkg;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BRACE  = 8'h7D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  localparam int MAX_BYTES   = 4;
  localparam int QUEUE_DEPTH = 2;

  // One accepted item turned into the list of link bytes it causes.
  typedef struct packed {
    logic [1:0]                     last_idx;
    logic [MAX_BYTES-1:0][7:0]      bytes;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == CH_BRACE) || (b == CH_DOLLAR) || (b == CH_HASH) || (b == CH_STAR);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'h0, nib};
    end else begin
      res = 8'h61 + {4'h0, nib} - 8'd10;
    end
    return res;
  endfunction

endpackage

FILE: sv/rspf_in_if.sv
// Input channel of the RSP framer: one payload byte or an end-of-packet mark.
// Uses rspf_pkg for nothing; stands on its own.
interface rspf_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

FILE: sv/rspf_out_if.sv
// Output channel of the RSP framer: one byte of the framed link stream.
// Stands on its own.
interface rspf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: sv/rsp_packet_framer_escaper_core.sv
// Top level of the RSP packet framer and escaper: front, job queue and back.
// Depends on rspf_pkg, rspf_in_if, rspf_out_if, rspf_front, rspf_queue, rspf_back.
//
//   channel   | dir | payload                   | handshake
//   in_item   | in  | opcode, data_byte         | valid/ready
//   out_item  | out | out_byte, last_of_run     | valid/ready
//
// The output link moves one byte per cycle while out_item.ready holds; an item
// yields 1 to 4 bytes, 2 for an escaped payload byte (3 if it opens the packet).
// The front takes an item in any cycle the job queue has room; each item is
// written to the job queue, then its bytes go to the back's output register.
// Reset (rst, synchronous) closes any open packet, clears the sum and empties
// the queue. A stalled output holds its byte while the queue keeps filling.
module rsp_packet_framer_escaper_core #(
  parameter int QUEUE_DEPTH = rspf_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  rspf_in_if.sink    in_item,
  rspf_out_if.source out_item
);

  rspf_pkg::job_t      wr_job;
  rspf_pkg::job_t      head;
  rspf_pkg::q_status_t q_stat;
  logic                push;
  logic                pop;

  rspf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_item),
    .q_stat  (q_stat),
    .push    (push),
    .job     (wr_job)
  );

  rspf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .head   (head),
    .stat   (q_stat)
  );

  rspf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

FILE: sv/rspf_front.sv
// Front of the RSP framer: accepts items, keeps the packet state and the
// running sum, and builds the byte list for each item.
// Depends on rspf_pkg and rspf_in_if.
module rspf_front (
  input  logic             clk,
  input  logic             rst,
  rspf_in_if.sink          in_item,
  input  rspf_pkg::q_status_t q_stat,
  output logic             push,
  output rspf_pkg::job_t   job
);

  logic       in_packet;
  logic [7:0] running_sum;
  logic       esc;
  logic [7:0] esc_byte;
  logic [7:0] sum_add;
  logic       is_end;

  assign in_item.ready = !q_stat.full;
  assign push          = in_item.valid && !q_stat.full;
  assign is_end        = (in_item.opcode == rspf_pkg::OP_END);

  assign esc      = rspf_pkg::needs_escape(in_item.data_byte);
  assign esc_byte = in_item.data_byte ^ rspf_pkg::ESC_XOR;
  // The sum covers the payload bytes as they go out on the link, escape marker included; the leading $ is not summed.
  assign sum_add  = esc ? (rspf_pkg::CH_BRACE + esc_byte) : in_item.data_byte;

  always_comb begin
    job = '0;
    priority if (is_end) begin
      if (in_packet) begin
        job.bytes[0] = rspf_pkg::CH_HASH;
        job.bytes[1] = rspf_pkg::hex_char(running_sum[7:4]);
        job.bytes[2] = rspf_pkg::hex_char(running_sum[3:0]);
        job.last_idx = 2'd2;
      end else begin
        job.bytes[0] = rspf_pkg::CH_DOLLAR;
        job.bytes[1] = rspf_pkg::CH_HASH;
        job.bytes[2] = rspf_pkg::hex_char(running_sum[7:4]);
        job.bytes[3] = rspf_pkg::hex_char(running_sum[3:0]);
        job.last_idx = 2'd3;
      end
    end else if (esc) begin
      if (in_packet) begin
        job.bytes[0] = rspf_pkg::CH_BRACE;
        job.bytes[1] = esc_byte;
        job.last_idx = 2'd1;
      end else begin
        job.bytes[0] = rspf_pkg::CH_DOLLAR;
        job.bytes[1] = rspf_pkg::CH_BRACE;
        job.bytes[2] = esc_byte;
        job.last_idx = 2'd2;
      end
    end else begin
      if (in_packet) begin
        job.bytes[0] = in_item.data_byte;
        job.last_idx = 2'd0;
      end else begin
        job.bytes[0] = rspf_pkg::CH_DOLLAR;
        job.bytes[1] = in_item.data_byte;
        job.last_idx = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet   <= 1'b0;
      running_sum <= 8'h00;
    end else if (push) begin
      if (is_end) begin
        in_packet   <= 1'b0;
        running_sum <= 8'h00;
      end else begin
        in_packet   <= 1'b1;
        running_sum <= running_sum + sum_add;
      end
    end
  end

  // An end item must leave the packet state closed and the sum cleared.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (push && is_end) |=> (!in_packet && running_sum == 8'h00))
    else $error("packet state not cleared after end item");

endmodule

FILE: sv/rspf_queue.sv
// Short job queue between the front and the back of the RSP framer, so that
// each side can stall on its own. Depends on rspf_pkg.
module rspf_queue #(
  parameter int DEPTH = rspf_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rspf_pkg::job_t      wr_job,
  input  logic                pop,
  output rspf_pkg::job_t      head,
  output rspf_pkg::q_status_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rspf_pkg::job_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign head       = entries[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("job queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("job queue count beyond depth");

endmodule

FILE: sv/rspf_back.sv
// Back of the RSP framer: walks the head job of the queue one byte per cycle
// when not stalled into the output register. Depends on rspf_pkg, rspf_out_if.
module rspf_back (
  input  logic                clk,
  input  logic                rst,
  input  rspf_pkg::job_t      head,
  input  rspf_pkg::q_status_t q_stat,
  output logic                pop,
  rspf_out_if.source          out_item
);

  logic       o_valid;
  logic [7:0] o_byte;
  logic       o_last;
  logic [1:0] idx;
  logic       load_ok;
  logic       emit;
  logic       at_last;

  assign load_ok = !o_valid || out_item.ready;
  assign emit    = load_ok && !q_stat.empty;
  assign at_last = (idx == head.last_idx);
  assign pop     = emit && at_last;

  assign out_item.valid       = o_valid;
  assign out_item.out_byte    = o_byte;
  assign out_item.last_of_run = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      idx     <= 2'd0;
    end else if (load_ok) begin
      o_valid <= !q_stat.empty;
      if (emit) begin
        idx <= at_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_byte <= head.bytes[idx];
      o_last <= at_last;
    end
  end

  // The byte index never runs past the end of the job it is walking.
  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    !q_stat.empty |-> (idx <= head.last_idx))
    else $error("byte index beyond end of job");

  // Taking the final byte of a job always returns the index to the start.
  a_idx_wraps: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == 2'd0))
    else $error("byte index not reset after job");

endmodule
